// ===== sv/first_seen_line_marker_unit_assert.svh =====
// Assertion macros for the line marker. Both macros sample on the rising
// edge of clk; the first is switched off while reset is applied.
`ifndef FIRST_SEEN_LINE_MARKER_UNIT_ASSERT_SVH
`define FIRST_SEEN_LINE_MARKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FSLM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FSLM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FSLM_ASSERT(lbl, prop, msg)
`define FSLM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== sv/fslm_pkg.sv =====
package fslm_pkg;

    typedef logic [2:0] count_t;

    localparam count_t COUNT_SAT     = 3'd4;
    localparam count_t NAV_SB_LIMIT  = 3'd3;
    localparam count_t DATA_SB_LIMIT = 3'd1;

    localparam logic [15:0] TAG_SINGLE_BAND = 16'd1;
    localparam logic [15:0] TAG_MULTI_BAND  = 16'd0;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_LINE_COUNT      = 2'd0;
    localparam cfg_index_t REG_PARTITION_COUNT = 2'd1;
    localparam cfg_index_t REG_SLICE_COUNT     = 2'd2;

    // Classification of one header.
    typedef struct packed {
        logic examined;
        logic navig;
        logic ok;
    } fslm_dec_t;

    // Status of the clearing pass after reset.
    typedef struct packed {
        logic busy;
        logic nav_wr;
    } fslm_clr_t;

endpackage

// ===== sv/fslm_mem.sv =====
module fslm_mem
    import fslm_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  count_t        wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output count_t        rdata
);

    count_t mem [DEPTH];
    count_t rdata_reg;

    // A read in the same cycle as a write to the same entry returns the old value.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/fslm_clear.sv =====
module fslm_clear
    import fslm_pkg::*;
#(
    parameter int DEPTH     = 65536,
    parameter int NAV_DEPTH = 256,
    parameter int AW        = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    output logic [AW-1:0] addr,
    output fslm_clr_t     status
);

    logic [AW-1:0] addr_reg;
    logic          busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (addr_reg == AW'(DEPTH - 1))
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                addr_reg <= addr_reg + AW'(1);
            end
        end
    end

    // The navigator store is smaller and is cleared during the first part of the sweep.
    assign addr          = addr_reg;
    assign status.busy   = busy_reg;
    assign status.nav_wr = busy_reg && (32'(addr_reg) < NAV_DEPTH);

endmodule

// ===== sv/fslm_decode.sv =====
module fslm_decode
    import fslm_pkg::*;
#(
    parameter int MAX_LINES      = 256,
    parameter int MAX_PARTITIONS = 16,
    parameter int MAX_SLICES     = 16
)
(
    input  logic [7:0]  line_index,
    input  logic [3:0]  partition_index,
    input  logic [3:0]  slice_index,
    input  logic [15:0] repetition_index,
    input  logic        is_calibration,
    input  logic        is_phase_correction,
    input  logic [8:0]  line_count,
    input  logic [4:0]  partition_count,
    input  logic [4:0]  slice_count,
    output fslm_dec_t   dec
);

    logic part_ok;
    logic slice_ok;
    logic line_ok;

    // An index must lie below both its register and the store's built size.
    assign part_ok  = ({1'b0, partition_index} < partition_count) &&
                      ({28'd0, partition_index} < 32'(MAX_PARTITIONS));
    assign slice_ok = ({1'b0, slice_index} < slice_count) &&
                      ({28'd0, slice_index} < 32'(MAX_SLICES));
    assign line_ok  = ({1'b0, line_index} < line_count) &&
                      ({24'd0, line_index} < 32'(MAX_LINES));

    assign dec.examined = (repetition_index == 16'd0) && !is_calibration;
    assign dec.navig    = is_phase_correction;
    assign dec.ok       = part_ok && slice_ok && (is_phase_correction || line_ok);

endmodule

// ===== sv/first_seen_line_marker_unit.sv =====
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  line, partition, slice, repetition, flags, tag
// out      output     out_valid/out_stall user_tag_out, index_error
// cfg      input      cfg_write          cfg_index, cfg_data
//
// One header per cycle is taken unless in_stall; it goes via read stage to output reg.
// Each counted header does one read-modify-write of one count; the last write is
// forwarded so that back-to-back headers on the same entry see the new count.
// After reset a clearing pass sweeps the data store, one entry a cycle (the store has
// at most 65536 entries), with in_stall high.
// A stalled output holds in its register while one more header waits in the read stage.
module first_seen_line_marker_unit
    import fslm_pkg::*;
#(
    parameter int MAX_LINES      = 256,
    parameter int MAX_PARTITIONS = 16,
    parameter int MAX_SLICES     = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  cfg_index_t             cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             line_index,
    input  logic [3:0]             partition_index,
    input  logic [3:0]             slice_index,
    input  logic [15:0]            repetition_index,
    input  logic                   is_calibration,
    input  logic                   is_phase_correction,
    input  logic [15:0]            user_tag_in,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [15:0]            user_tag_out,
    output logic                   index_error
);

`include "first_seen_line_marker_unit_assert.svh"

    localparam int L_USED     = (MAX_LINES < 256) ? MAX_LINES : 256;
    localparam int P_USED     = (MAX_PARTITIONS < 16) ? MAX_PARTITIONS : 16;
    localparam int S_USED     = (MAX_SLICES < 16) ? MAX_SLICES : 16;
    localparam int DATA_DEPTH = L_USED * P_USED * S_USED;
    localparam int NAV_DEPTH  = P_USED * S_USED;
    localparam int DATA_AW    = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
    localparam int NAV_AW     = (NAV_DEPTH > 1) ? $clog2(NAV_DEPTH) : 1;

    // Configuration registers.
    logic [8:0] line_count_reg;
    logic [4:0] partition_count_reg;
    logic [4:0] slice_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg      <= 9'd256;
            partition_count_reg <= 5'd1;
            slice_count_reg     <= 5'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LINE_COUNT:      line_count_reg      <= cfg_data;
                REG_PARTITION_COUNT: partition_count_reg <= cfg_data[4:0];
                REG_SLICE_COUNT:     slice_count_reg     <= cfg_data[4:0];
                default:             ;
            endcase
        end
    end

    // Clearing pass.
    logic [DATA_AW-1:0] clr_addr;
    fslm_clr_t          clr;

    fslm_clear #(
        .DEPTH     (DATA_DEPTH),
        .NAV_DEPTH (NAV_DEPTH),
        .AW        (DATA_AW)
    ) u_clear (
        .clk    (clk),
        .rst_n  (rst_n),
        .addr   (clr_addr),
        .status (clr)
    );

    // Header classification.
    fslm_dec_t dec;

    fslm_decode #(
        .MAX_LINES      (MAX_LINES),
        .MAX_PARTITIONS (MAX_PARTITIONS),
        .MAX_SLICES     (MAX_SLICES)
    ) u_decode (
        .line_index          (line_index),
        .partition_index     (partition_index),
        .slice_index         (slice_index),
        .repetition_index    (repetition_index),
        .is_calibration      (is_calibration),
        .is_phase_correction (is_phase_correction),
        .line_count          (line_count_reg),
        .partition_count     (partition_count_reg),
        .slice_count         (slice_count_reg),
        .dec                 (dec)
    );

    // Read stage and output register.
    logic               s1_valid_reg;
    logic [15:0]        s1_tag_reg;
    logic               s1_counted_reg;
    logic               s1_navig_reg;
    logic               s1_err_reg;
    logic [DATA_AW-1:0] s1_data_addr_reg;
    logic [NAV_AW-1:0]  s1_nav_addr_reg;

    logic               out_valid_reg;
    logic [15:0]        out_tag_reg;
    logic               out_err_reg;

    // Record of the most recent count written back.
    logic               lw_valid_reg;
    logic               lw_navig_reg;
    logic [DATA_AW-1:0] lw_data_addr_reg;
    logic [NAV_AW-1:0]  lw_nav_addr_reg;
    count_t             lw_count_reg;

    logic               in_accept;
    logic               in_counted;
    logic               s1_move;
    logic               s1_write;
    logic [DATA_AW-1:0] in_data_addr;
    logic [NAV_AW-1:0]  in_nav_addr;
    count_t             data_rdata;
    count_t             nav_rdata;
    count_t             old_count;
    count_t             count_next;
    logic               fwd_hit;
    logic [15:0]        tag_next;
    logic               out_tag_is_flag;

    assign s1_move   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = clr.busy || (s1_valid_reg && !s1_move);
    assign in_accept = in_valid && !in_stall;
    assign in_counted = dec.examined && dec.ok;
    assign s1_write  = s1_move && s1_counted_reg;

    assign in_data_addr = DATA_AW'(((int'(line_index) * P_USED + int'(partition_index))
                                    * S_USED) + int'(slice_index));
    assign in_nav_addr  = NAV_AW'((int'(partition_index) * S_USED) + int'(slice_index));

    assign fwd_hit = lw_valid_reg && (lw_navig_reg == s1_navig_reg) &&
                     (s1_navig_reg ? (lw_nav_addr_reg == s1_nav_addr_reg)
                                   : (lw_data_addr_reg == s1_data_addr_reg));

    always_comb
    begin
        if (fwd_hit)
        begin
            old_count = lw_count_reg;
        end
        else
        begin
            old_count = s1_navig_reg ? nav_rdata : data_rdata;
        end
        count_next = (old_count < COUNT_SAT) ? old_count + count_t'(1) : old_count;
        if (!s1_counted_reg)
        begin
            tag_next = s1_tag_reg;
        end
        else if (s1_navig_reg)
        begin
            tag_next = (count_next <= NAV_SB_LIMIT) ? TAG_SINGLE_BAND : TAG_MULTI_BAND;
        end
        else
        begin
            tag_next = (count_next <= DATA_SB_LIMIT) ? TAG_SINGLE_BAND : TAG_MULTI_BAND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lw_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (s1_write)
            begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_tag_reg       <= user_tag_in;
            s1_counted_reg   <= in_counted;
            s1_navig_reg     <= dec.navig;
            s1_err_reg       <= dec.examined && !dec.ok;
            s1_data_addr_reg <= in_data_addr;
            s1_nav_addr_reg  <= in_nav_addr;
        end
        if (s1_move)
        begin
            out_tag_reg <= tag_next;
            out_err_reg <= s1_err_reg;
        end
        if (s1_write)
        begin
            lw_navig_reg     <= s1_navig_reg;
            lw_data_addr_reg <= s1_data_addr_reg;
            lw_nav_addr_reg  <= s1_nav_addr_reg;
            lw_count_reg     <= count_next;
        end
    end

    // Memory ports: the clearing pass owns the write ports until it ends.
    logic               data_we;
    logic [DATA_AW-1:0] data_waddr;
    count_t             data_wdata;
    logic               nav_we;
    logic [NAV_AW-1:0]  nav_waddr;
    count_t             nav_wdata;

    assign data_we    = clr.busy || (s1_write && !s1_navig_reg);
    assign data_waddr = clr.busy ? clr_addr : s1_data_addr_reg;
    assign data_wdata = clr.busy ? '0 : count_next;
    assign nav_we     = clr.nav_wr || (s1_write && s1_navig_reg);
    assign nav_waddr  = clr.busy ? clr_addr[NAV_AW-1:0] : s1_nav_addr_reg;
    assign nav_wdata  = clr.busy ? '0 : count_next;

    fslm_mem #(
        .DEPTH (DATA_DEPTH),
        .AW    (DATA_AW)
    ) u_data_mem (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .re    (in_accept && in_counted && !dec.navig),
        .raddr (in_data_addr),
        .rdata (data_rdata)
    );

    fslm_mem #(
        .DEPTH (NAV_DEPTH),
        .AW    (NAV_AW)
    ) u_nav_mem (
        .clk   (clk),
        .we    (nav_we),
        .waddr (nav_waddr),
        .wdata (nav_wdata),
        .re    (in_accept && in_counted && dec.navig),
        .raddr (in_nav_addr),
        .rdata (nav_rdata)
    );

    assign out_valid    = out_valid_reg;
    assign user_tag_out = out_tag_reg;
    assign index_error  = out_err_reg;

    assign out_tag_is_flag = (out_tag_reg == TAG_SINGLE_BAND) || (out_tag_reg == TAG_MULTI_BAND);

    `FSLM_ASSERT_ALWAYS(a_no_accept_while_clearing, clr.busy |-> in_stall, "accept while clearing")
    `FSLM_ASSERT(a_one_store_written, !clr.busy |-> !(data_we && nav_we), "both stores written")
    `FSLM_ASSERT(a_counted_tag_is_flag, s1_write |=> out_tag_is_flag, "counted tag not a flag")
    `FSLM_ASSERT(a_err_not_counted, s1_valid_reg && s1_err_reg |-> !s1_counted_reg, "error counted")

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    import fslm_pkg::*;

    localparam int MAX_LINES      = 256;
    localparam int MAX_PARTITIONS = 16;
    localparam int MAX_SLICES     = 16;
    localparam int ITEMS_PER_PHASE = 165;
    localparam int NUM_PHASES      = 7;
    localparam int NUM_DIRECTED    = 22;
    localparam int DRAIN_CYCLES    = 8;

    // The register list has three entries, so index 3 is a hole in the map.
    localparam cfg_index_t REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0]  line;
        logic [3:0]  part;
        logic [3:0]  slc;
        logic [15:0] rep;
        logic        calib;
        logic        nav;
        logic [15:0] tag;
    } header_t;

    typedef struct packed {
        logic [15:0] tag;
        logic        err;
    } mark_t;

    typedef struct packed {
        header_t hdr;
        logic    typed;
        mark_t   want;
    } row_t;

    // Reset settings apply: 256 lines, one partition, one slice.
    localparam row_t DIRECTED_ROWS [0:NUM_DIRECTED-1] = '{
        '{'{8'd0,   4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 16'h1234}, 1'b1, '{16'h0001, 1'b0}},
        '{'{8'd0,   4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 16'h1234}, 1'b1, '{16'h0000, 1'b0}},
        '{'{8'd255, 4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 16'hFFFF}, 1'b1, '{16'h0001, 1'b0}},
        '{'{8'd255, 4'd15, 4'd0,  16'h0000, 1'b0, 1'b0, 16'hFFFF}, 1'b1, '{16'hFFFF, 1'b1}},
        '{'{8'd0,   4'd0,  4'd15, 16'h0000, 1'b0, 1'b0, 16'h00FF}, 1'b1, '{16'h00FF, 1'b1}},
        '{'{8'd0,   4'd0,  4'd0,  16'hFFFF, 1'b0, 1'b0, 16'hABCD}, 1'b1, '{16'hABCD, 1'b0}},
        '{'{8'd0,   4'd0,  4'd0,  16'h0001, 1'b0, 1'b1, 16'h0000}, 1'b1, '{16'h0000, 1'b0}},
        '{'{8'd0,   4'd0,  4'd0,  16'h0000, 1'b1, 1'b0, 16'h5A5A}, 1'b1, '{16'h5A5A, 1'b0}},
        '{'{8'd255, 4'd15, 4'd15, 16'h0000, 1'b1, 1'b1, 16'hFFFF}, 1'b1, '{16'hFFFF, 1'b0}},
        '{'{8'd0,   4'd0,  4'd0,  16'h0000, 1'b0, 1'b1, 16'h8000}, 1'b1, '{16'h0001, 1'b0}},
        '{'{8'd0,   4'd0,  4'd0,  16'h0000, 1'b0, 1'b1, 16'h8000}, 1'b1, '{16'h0001, 1'b0}},
        '{'{8'd0,   4'd0,  4'd0,  16'h0000, 1'b0, 1'b1, 16'h8000}, 1'b1, '{16'h0001, 1'b0}},
        '{'{8'd0,   4'd0,  4'd0,  16'h0000, 1'b0, 1'b1, 16'h8000}, 1'b1, '{16'h0000, 1'b0}},
        '{'{8'd0,   4'd0,  4'd0,  16'h0000, 1'b0, 1'b1, 16'h8000}, 1'b1, '{16'h0000, 1'b0}},
        '{'{8'd255, 4'd0,  4'd0,  16'h0000, 1'b0, 1'b1, 16'h7FFF}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'd0,   4'd15, 4'd15, 16'h0000, 1'b0, 1'b1, 16'h0F0F}, 1'b1, '{16'h0F0F, 1'b1}},
        '{'{8'd0,   4'd1,  4'd0,  16'h0000, 1'b0, 1'b1, 16'hF0F0}, 1'b1, '{16'hF0F0, 1'b1}},
        '{'{8'd0,   4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 16'h0002}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'd0,   4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 16'h0003}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'd128, 4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 16'h0000}, 1'b0, '{16'h0000, 1'b0}},
        '{'{8'd255, 4'd15, 4'd15, 16'h8000, 1'b0, 1'b0, 16'h3C3C}, 1'b1, '{16'h3C3C, 1'b0}},
        '{'{8'd255, 4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 16'h1111}, 1'b0, '{16'h0000, 1'b0}}
    };

    // Settings per random phase: minimum, maximum, above maximum, zero and
    // values with bits above the register width.
    localparam logic [8:0] PHASE_LINES [0:NUM_PHASES-1] =
        '{9'd4, 9'd256, 9'd1,  9'd511, 9'd0, 9'd16,   9'd12};
    localparam logic [8:0] PHASE_PARTS [0:NUM_PHASES-1] =
        '{9'd2, 9'd16,  9'd1,  9'd31,  9'd3, 9'h1E3,  9'd4};
    localparam logic [8:0] PHASE_SLICES [0:NUM_PHASES-1] =
        '{9'd2, 9'd16,  9'd16, 9'd31,  9'd4, 9'h102,  9'd0};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    cfg_index_t  cfg_index = REG_LINE_COUNT;
    logic [8:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  line_index = '0;
    logic [3:0]  partition_index = '0;
    logic [3:0]  slice_index = '0;
    logic [15:0] repetition_index = '0;
    logic        is_calibration = 1'b0;
    logic        is_phase_correction = 1'b0;
    logic [15:0] user_tag_in = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] user_tag_out;
    logic        index_error;

    // Local copy of the block state and its size registers.
    logic [2:0] data_counts [0:MAX_LINES*MAX_PARTITIONS*MAX_SLICES-1];
    logic [2:0] nav_counts [0:MAX_PARTITIONS*MAX_SLICES-1];
    logic [8:0] line_reg = 9'd256;
    logic [4:0] part_reg = 5'd1;
    logic [4:0] slice_reg = 5'd1;

    mark_t expected_marks [$];
    int    failures = 0;
    int    sent_count = 0;
    logic  calm = 1'b0;

    first_seen_line_marker_unit dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !calm && ($urandom_range(99) < 13);
    end

    function automatic int unsigned eff_size(input int unsigned value, input int unsigned limit);
        return (value > limit) ? limit : value;
    endfunction

    function automatic mark_t mark_header(input header_t h);
        mark_t       m;
        logic        ok;
        int unsigned idx;
        m.tag = h.tag;
        m.err = 1'b0;
        if (h.rep == 16'd0 && !h.calib)
        begin
            ok = h.part < eff_size(part_reg, MAX_PARTITIONS)
                && h.slc < eff_size(slice_reg, MAX_SLICES);
            if (!h.nav)
                ok = ok && h.line < eff_size(line_reg, MAX_LINES);
            if (!ok)
                m.err = 1'b1;
            else if (h.nav)
            begin
                idx = h.part * MAX_SLICES + h.slc;
                if (nav_counts[idx] < COUNT_SAT)
                    nav_counts[idx] = nav_counts[idx] + 3'd1;
                m.tag = (nav_counts[idx] <= NAV_SB_LIMIT) ? TAG_SINGLE_BAND : TAG_MULTI_BAND;
            end
            else
            begin
                idx = (h.line * MAX_PARTITIONS + h.part) * MAX_SLICES + h.slc;
                if (data_counts[idx] < COUNT_SAT)
                    data_counts[idx] = data_counts[idx] + 3'd1;
                m.tag = (data_counts[idx] <= DATA_SB_LIMIT) ? TAG_SINGLE_BAND : TAG_MULTI_BAND;
            end
        end
        return m;
    endfunction

    // Mostly counted headers inside the configured sizes, with lines packed
    // into a narrow window half the time so entries are seen repeatedly.
    function automatic header_t random_header();
        header_t     h;
        int unsigned eff_l;
        int unsigned eff_p;
        int unsigned eff_s;
        eff_l = eff_size(line_reg, MAX_LINES);
        eff_p = eff_size(part_reg, MAX_PARTITIONS);
        eff_s = eff_size(slice_reg, MAX_SLICES);
        h.line  = 8'($urandom);
        h.part  = 4'($urandom);
        h.slc   = 4'($urandom);
        h.rep   = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom);
        h.calib = 1'($urandom_range(1));
        h.nav   = 1'($urandom_range(1));
        h.tag   = 16'($urandom);
        if ($urandom_range(99) < 80)
        begin
            h.rep   = 16'd0;
            h.calib = 1'b0;
            h.nav   = ($urandom_range(3) == 0);
            if (eff_l > 0)
                h.line = ($urandom_range(1) == 0) ? 8'($urandom_range(eff_l - 1))
                    : 8'($urandom_range(((eff_l < 8) ? eff_l : 8) - 1));
            if (eff_p > 0)
                h.part = 4'($urandom_range(eff_p - 1));
            if (eff_s > 0)
                h.slc = 4'($urandom_range(eff_s - 1));
        end
        return h;
    endfunction

    task automatic send_header(input header_t h, input logic typed, input mark_t want);
        mark_t m;
        while (!calm && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        line_index          <= h.line;
        partition_index     <= h.part;
        slice_index         <= h.slc;
        repetition_index    <= h.rep;
        is_calibration      <= h.calib;
        is_phase_correction <= h.nav;
        user_tag_in         <= h.tag;
        in_valid            <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        // The transfer happened at this edge.
        m = mark_header(h);
        expected_marks.push_back(typed ? want : m);
        sent_count = sent_count + 1;
        calm <= (sent_count >= 450 && sent_count < 650);
    endtask

    // Write enable is left high so that back-to-back writes keep it steady.
    task automatic put_reg(input cfg_index_t idx, input logic [8:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_LINE_COUNT:      line_reg = value;
            REG_PARTITION_COUNT: part_reg = value[4:0];
            REG_SLICE_COUNT:     slice_reg = value[4:0];
            default:             ;
        endcase
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_marks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : check_marks
        mark_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_marks.size() == 0)
            begin
                if (failures < 50)
                    $display("%0t: unexpected result tag %h error %b",
                        $time, user_tag_out, index_error);
                failures = failures + 1;
            end
            else
            begin
                want = expected_marks.pop_front();
                if (user_tag_out !== want.tag)
                begin
                    if (failures < 50)
                        $display("%0t: user_tag_out expected %h actual %h",
                            $time, want.tag, user_tag_out);
                    failures = failures + 1;
                end
                if (index_error !== want.err)
                begin
                    if (failures < 50)
                        $display("%0t: index_error expected %b actual %b",
                            $time, want.err, index_error);
                    failures = failures + 1;
                end
            end
        end
    end

    initial
    begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < MAX_LINES * MAX_PARTITIONS * MAX_SLICES; i++)
            data_counts[i] = 3'd0;
        for (int i = 0; i < MAX_PARTITIONS * MAX_SLICES; i++)
            nav_counts[i] = 3'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_header(DIRECTED_ROWS[i].hdr, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            put_reg(REG_LINE_COUNT, PHASE_LINES[p]);
            put_reg(REG_PARTITION_COUNT, PHASE_PARTS[p]);
            put_reg(REG_SLICE_COUNT, PHASE_SLICES[p]);
            if (p == 2)
                put_reg(REG_UNUSED, 9'h1FF);
            cfg_write <= 1'b0;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_header(random_header(), 1'b0, '0);
        end
        wait_idle();

        if (expected_marks.size() != 0)
            failures = failures + 1;
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/fslm_pkg.sv
sv/fslm_mem.sv
sv/fslm_clear.sv
sv/fslm_decode.sv
sv/first_seen_line_marker_unit.sv
tb/sv/tb.sv
